@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ src/dbsg_pkg.sv @@
package dbsg_pkg;

    localparam int SYM_W        = 4;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_ALPHABET = 10;

    localparam logic [CFG_W-1:0] ALPHABET_RESET = 4'd2;
    localparam logic [CFG_W-1:0] ORDER_RESET    = 4'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ALPHABET = 2'd0;
    localparam t_cfg_idx CFG_ORDER    = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_EXT,
        S_STRIP,
        S_DIV
    } t_state;

    typedef struct packed {
        logic clr;
        logic we;
    } t_rf_ctl;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [SYM_W-1:0] sym;
    } t_emit;

endpackage

@@ src/de_bruijn_sequence_generator.sv @@
// Streams the lexicographically least de Bruijn sequence B(k,n), one symbol per input
// transfer, with tlast on the final symbol, after which the sequence starts over; restart
// (tdata bit 0) or a write to the alphabet or order register returns to the first symbol.
// A symbol inside a Lyndon word is accepted (S_IDLE) and then emitted (S_EMIT). A symbol
// that ends a word adds the successor search, done by a sequencer that walks the word
// register one digit per cycle: periodic extension, a scan over trailing k-1 digits, and
// repeated subtraction to test whether the new length m divides n; failed attempts repeat
// the extension.
module de_bruijn_sequence_generator #(
    parameter int MAX_ORDER = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dbsg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dbsg_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [0] restart, rest zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [3:0] symbol, rest zero
    output logic                              m_axis_tlast
);
    import dbsg_pkg::*;

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int LW = $clog2(MAX_ORDER + 1);

    logic [CFG_W-1:0] r_alpha;
    logic [CFG_W-1:0] r_order;
    logic             r_out_vld;
    logic [SYM_W-1:0] r_out_sym;
    logic             r_out_last;

    logic [SYM_W-1:0] k_eff;
    logic [LW-1:0]    n_eff;
    logic             cfg_restart;
    logic             out_free;
    t_emit            emit;
    t_rf_ctl          rf_ctl;
    logic [IW-1:0]    rf_raddr;
    logic [IW-1:0]    rf_waddr;
    logic [SYM_W-1:0] rf_wdata;
    logic [SYM_W-1:0] rf_rdata;

    assign cfg_restart = i_cfg_we && (i_cfg_idx == CFG_ALPHABET || i_cfg_idx == CFG_ORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHABET_RESET;
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ALPHABET) r_alpha <= i_cfg_data;
            if (i_cfg_idx == CFG_ORDER)    r_order <= i_cfg_data;
        end
    end

    // saturate k to 1..10 and n to 1..MAX_ORDER
    always_comb begin
        if (r_alpha == '0)                k_eff = 4'd1;
        else if (r_alpha > MAX_ALPHABET)  k_eff = SYM_W'(MAX_ALPHABET);
        else                              k_eff = r_alpha;
        if (r_order == '0)                n_eff = LW'(1);
        else if (r_order > MAX_ORDER)     n_eff = LW'(MAX_ORDER);
        else                              n_eff = LW'(r_order);
    end

    assign out_free = !r_out_vld || m_axis_tready;

    dbsg_seq #(
        .IW (IW),
        .LW (LW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_k           (k_eff),
        .i_n           (n_eff),
        .i_cfg_restart (cfg_restart),
        .i_in_valid    (s_axis_tvalid),
        .i_restart     (s_axis_tdata[0]),
        .o_in_ready    (s_axis_tready),
        .i_out_free    (out_free),
        .o_emit        (emit),
        .o_rf          (rf_ctl),
        .o_raddr       (rf_raddr),
        .o_waddr       (rf_waddr),
        .o_wdata       (rf_wdata),
        .i_rdata       (rf_rdata)
    );

    dbsg_word_rf #(
        .DEPTH (MAX_ORDER),
        .IW    (IW)
    ) u_word_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rf_ctl),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    // output register holds the symbol while the downstream stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit.vld) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.vld) begin
            r_out_sym  <= emit.sym;
            r_out_last <= emit.last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out_sym};
    assign m_axis_tlast  = r_out_last;

endmodule

@@ src/dbsg_word_rf.sv @@
module dbsg_word_rf #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dbsg_pkg::t_rf_ctl        i_ctl,
    input  logic [IW-1:0]            i_waddr,
    input  logic [dbsg_pkg::SYM_W-1:0] i_wdata,
    input  logic [IW-1:0]            i_raddr,
    output logic [dbsg_pkg::SYM_W-1:0] o_rdata
);
    import dbsg_pkg::*;

    logic [SYM_W-1:0] r_word [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            for (int e = 0; e < DEPTH; e++) begin
                r_word[e] <= '0;
            end
        end else if (i_ctl.we) begin
            r_word[i_waddr] <= i_wdata;
        end
    end

    // single read port, shared by emit, extension and strip scan
    assign o_rdata = r_word[i_raddr];

endmodule

@@ src/dbsg_seq.sv @@
`include "assert_macros.svh"

module dbsg_seq #(
    parameter int IW = 3,
    parameter int LW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [dbsg_pkg::SYM_W-1:0]  i_k,
    input  logic [LW-1:0]               i_n,
    input  logic                        i_cfg_restart,
    input  logic                        i_in_valid,
    input  logic                        i_restart,
    output logic                        o_in_ready,
    input  logic                        i_out_free,
    output dbsg_pkg::t_emit             o_emit,
    output dbsg_pkg::t_rf_ctl           o_rf,
    output logic [IW-1:0]               o_raddr,
    output logic [IW-1:0]               o_waddr,
    output logic [dbsg_pkg::SYM_W-1:0]  o_wdata,
    input  logic [dbsg_pkg::SYM_W-1:0]  i_rdata
);
    import dbsg_pkg::*;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [IW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [LW-1:0] r_m, n_m;
    logic [LW-1:0] r_rem, n_rem;

    logic [SYM_W-1:0] k_top;
    logic [LW-1:0]    pos_inc;
    logic [LW-1:0]    j_inc;
    logic             clr_seq;
    logic             is_top;

    assign k_top   = i_k - 4'd1;
    assign pos_inc = LW'(r_pos) + LW'(1);
    assign j_inc   = LW'(r_j) + LW'(1);
    assign is_top  = (i_rdata == k_top);
    assign clr_seq = (r_state == S_IDLE && i_in_valid && i_restart) || i_cfg_restart ||
                     (r_state == S_STRIP && r_m == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) n_state = (pos_inc == r_len) ? S_EXT : S_IDLE;
            end
            S_EXT: begin
                if (r_i >= i_n) n_state = S_STRIP;
            end
            S_STRIP: begin
                if (r_m == '0) n_state = S_IDLE;
                else if (!is_top) n_state = S_DIV;
            end
            S_DIV: begin
                // repeated subtraction decides whether the new length divides n
                if (r_rem < r_len) n_state = (r_rem == '0) ? S_IDLE : S_EXT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_emit.vld  = (r_state == S_EMIT) && i_out_free;
        o_emit.sym  = i_rdata;
        o_emit.last = (r_len == LW'(1)) && is_top;
        o_rf.clr    = clr_seq;
        o_rf.we     = 1'b0;
        o_raddr     = r_pos;
        o_waddr     = IW'(r_i);
        o_wdata     = i_rdata;
        case (r_state)
            S_EXT: begin
                o_raddr = r_j;
                o_rf.we = (r_i < i_n);
            end
            S_STRIP: begin
                o_raddr = IW'(r_m - LW'(1));
                o_waddr = IW'(r_m - LW'(1));
                o_wdata = i_rdata + 4'd1;
                o_rf.we = (r_m != '0) && !is_top;
            end
            default: begin
                o_raddr = r_pos;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_len = r_len;
        n_pos = r_pos;
        n_i   = r_i;
        n_j   = r_j;
        n_m   = r_m;
        n_rem = r_rem;
        case (r_state)
            S_EMIT: begin
                if (i_out_free) begin
                    n_pos = IW'(pos_inc);
                    n_i   = r_len;
                    n_j   = '0;
                end
            end
            S_EXT: begin
                if (r_i < i_n) begin
                    n_i = r_i + LW'(1);
                    n_j = (j_inc == r_len) ? '0 : IW'(j_inc);
                end else begin
                    n_m = i_n;
                end
            end
            S_STRIP: begin
                if (r_m != '0) begin
                    if (is_top) begin
                        n_m = r_m - LW'(1);
                    end else begin
                        n_len = r_m;
                        n_rem = i_n;
                        n_pos = '0;
                    end
                end
            end
            S_DIV: begin
                if (r_rem >= r_len) begin
                    n_rem = r_rem - r_len;
                end else begin
                    n_i = r_len;
                    n_j = '0;
                end
            end
            default: begin
                n_len = r_len;
            end
        endcase
        if (clr_seq) begin
            n_len = LW'(1);
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LW'(1);
            r_pos   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_i     <= n_i;
            r_j     <= n_j;
            r_m     <= n_m;
            r_rem   <= n_rem;
        end
    end

    `ASSERT_ALWAYS(a_len_range, (r_len != '0) && (r_len <= i_n), "word length out of range")
    `ASSERT_IMPL(a_pos_in_word, r_state == S_IDLE, LW'(r_pos) < r_len, "emit index past word")
    `ASSERT_IMPL(a_sym_in_alphabet, o_emit.vld, o_emit.sym < i_k, "symbol outside alphabet")
    `ASSERT_NEXT(a_div_done, (r_state == S_DIV) && (r_rem == '0),
                 (r_state == S_IDLE) && (r_pos == '0), "accepted word not left ready")

endmodule

@@ tb/sv/tb_de_bruijn_sequence_generator.sv @@
module tb_de_bruijn_sequence_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import dbsg_pkg::*;

    localparam int MAX_ORDER  = 8;
    localparam int SETTLE     = 400;
    localparam int WD_LIMIT   = 20000;
    localparam int HOLD_OFF   = 150;
    localparam int PHASES     = 12;

    // indexes past the register list, written to check they are ignored
    localparam t_cfg_idx CFG_SPARE2 = 2'd2;
    localparam t_cfg_idx CFG_SPARE3 = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] data;
        logic             restart;
        logic             typed;
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_dir_row;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_symbol_exp;

    localparam int DIR_ROWS = 31;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // B(2,3) after reset: 0 001 011 1
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd1, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd1, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd1, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd1, 1'b1},
        // wrap, then restart in the middle
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b1, 1'b1, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        // single-symbol alphabet, and zero saturating to one
        '{ROW_CFG,  CFG_ALPHABET, 4'd1,  1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b1},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b1, 1'b1, 4'd0, 1'b1},
        '{ROW_CFG,  CFG_ALPHABET, 4'd0,  1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b1},
        // both registers above range
        '{ROW_CFG,  CFG_ALPHABET, 4'd15, 1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_CFG,  CFG_ORDER,    4'd15, 1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b0, 4'd0, 1'b0},
        // order zero saturates to one: sequence is 0,1,2
        '{ROW_CFG,  CFG_ORDER,    4'd0,  1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_CFG,  CFG_ALPHABET, 4'd3,  1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd1, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd2, 1'b1},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd0, 1'b0},
        // spare indexes neither change the setting nor restart
        '{ROW_CFG,  CFG_SPARE2,   4'd5,  1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd1, 1'b0},
        '{ROW_CFG,  CFG_SPARE3,   4'd15, 1'b0, 1'b0, 4'd0, 1'b0},
        '{ROW_ITEM, CFG_ALPHABET, 4'd0,  1'b0, 1'b1, 4'd2, 1'b1}
    };

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    t_cfg_idx         i_cfg_idx     = CFG_ALPHABET;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;   // [0] restart, rest zero
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;         // [3:0] symbol, rest zero
    logic             m_axis_tlast;

    de_bruijn_sequence_generator #(
        .MAX_ORDER(MAX_ORDER)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // predictor state
    logic [CFG_W-1:0] alphabet_reg = ALPHABET_RESET;
    logic [CFG_W-1:0] order_reg    = ORDER_RESET;
    logic [SYM_W-1:0] lw_word [MAX_ORDER];
    logic [3:0]       lw_len;
    logic [3:0]       lw_pos;

    t_symbol_exp pending_symbols [$];
    int          n_err     = 0;
    bit          gaps_on   = 1'b0;
    bit          stall_req = 1'b0;

    function automatic int unsigned eff_alphabet();
        if (alphabet_reg < 1) return 1;
        if (alphabet_reg > MAX_ALPHABET) return MAX_ALPHABET;
        return alphabet_reg;
    endfunction

    function automatic int unsigned eff_order();
        if (order_reg < 1) return 1;
        if (order_reg > MAX_ORDER) return MAX_ORDER;
        return order_reg;
    endfunction

    function automatic void clear_word();
        for (int i = 0; i < MAX_ORDER; i++) lw_word[i] = '0;
        lw_len = 4'd1;
        lw_pos = 4'd0;
    endfunction

    // FKM successor: extend periodically, strip trailing k-1, bump the last digit,
    // repeat until the new length divides n
    function automatic void next_lyndon_word();
        int unsigned k;
        int unsigned n;
        int unsigned len;
        int unsigned m;
        k   = eff_alphabet();
        n   = eff_order();
        len = lw_len;
        if (len < 1 || len > n) begin
            clear_word();
            return;
        end
        do begin
            for (int unsigned i = len; i < n; i++) lw_word[i] = lw_word[i - len];
            m = n;
            while (m > 0 && lw_word[m - 1] == k - 1) m--;
            if (m == 0) begin
                clear_word();
                return;
            end
            lw_word[m - 1] = lw_word[m - 1] + 4'd1;
            len = m;
        end while (n % len != 0);
        lw_len = 4'(len);
        lw_pos = 4'd0;
    endfunction

    function automatic void next_debruijn_symbol(input logic restart,
                                                 output logic [SYM_W-1:0] sym,
                                                 output logic last);
        int unsigned k;
        int unsigned n;
        k = eff_alphabet();
        n = eff_order();
        if (restart) clear_word();
        if (lw_len < 1 || lw_len > n || lw_pos >= lw_len) clear_word();
        sym    = lw_word[lw_pos];
        last   = (lw_len == 1) && (sym == k - 1);
        lw_pos = lw_pos + 4'd1;
        if (lw_pos >= lw_len) next_lyndon_word();
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // drop valid, wait until every symbol is back and the successor search is done
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ALPHABET) begin
            alphabet_reg = val;
            clear_word();
        end else if (idx == CFG_ORDER) begin
            order_reg = val;
            clear_word();
        end
    endtask

    task automatic send_item(input logic restart, input logic typed,
                             input logic [SYM_W-1:0] t_sym, input logic t_last);
        t_symbol_exp e;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        next_debruijn_symbol(restart, e.sym, e.last);
        if (typed) begin
            e.sym  = t_sym;
            e.last = t_last;
        end
        pending_symbols = {pending_symbols, e};
    endtask

    function automatic logic [CFG_W-1:0] pick_alphabet();
        case ($urandom_range(0, 9))
            0:       return 4'($urandom_range(0, 15));
            1:       return 4'd10;
            default: return 4'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_order();
        case ($urandom_range(0, 9))
            0:       return 4'($urandom_range(0, 15));
            1:       return 4'd8;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // receiver: random stalls, one long hold-off on request, checks every transfer
    initial begin : symbol_sink
        int          rx_gap;
        int          hold_left;
        t_symbol_exp e;
        rx_gap    = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (pending_symbols.size() == 0) begin
                    $display("%0t unexpected transfer: symbol %0d last %0b", $time,
                             m_axis_tdata[SYM_W-1:0], m_axis_tlast);
                    n_err++;
                end else begin
                    e = pending_symbols.pop_front();
                    if (m_axis_tdata[SYM_W-1:0] !== e.sym) begin
                        $display("%0t symbol mismatch: expected %0d, got %0d", $time,
                                 e.sym, m_axis_tdata[SYM_W-1:0]);
                        n_err++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $display("%0t last mismatch: expected %0b, got %0b", $time,
                                 e.last, m_axis_tlast);
                        n_err++;
                    end
                end
            end
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WD_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int unsigned n_items;
        bit          alpha_first;
        clear_word();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TAB[r].kind == ROW_CFG)
                write_reg(DIR_TAB[r].idx, DIR_TAB[r].data);
            else
                send_item(DIR_TAB[r].restart, DIR_TAB[r].typed, DIR_TAB[r].sym,
                          DIR_TAB[r].last);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            gaps_on     = (ph != PHASES - 1) && (ph % 4 != 1);
            alpha_first = $urandom_range(0, 1);
            if (alpha_first) write_reg(CFG_ALPHABET, pick_alphabet());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_ORDER, pick_order());
            if (!alpha_first) write_reg(CFG_ALPHABET, pick_alphabet());
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE2 : CFG_SPARE3,
                          4'($urandom_range(0, 15)));
            // receiver holds off while items keep coming, so the input backs up
            if (ph == 2) stall_req = 1'b1;
            n_items = $urandom_range(60, 90);
            for (int unsigned it = 0; it < n_items; it++)
                send_item($urandom_range(0, 31) == 0, 1'b0, '0, 1'b0);
        end

        settle();
        if (n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ de_bruijn_sequence_generator.f @@
+incdir+src
src/dbsg_pkg.sv
src/dbsg_word_rf.sv
src/dbsg_seq.sv
src/de_bruijn_sequence_generator.sv
tb/sv/tb_de_bruijn_sequence_generator.sv
